// ===== design/sopg_pkg.sv =====
`timescale 1ns / 1ps
// Package with the shared constants, payload types and tables of the outline point generator.
package sopg_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int STEPS = 4 * SINE_TABLE_DEPTH;
	localparam int STEP_W = $clog2(STEPS);

	localparam int SIZE_W = 12;
	localparam int IDX_W = 12;
	localparam int CNT_W = 13;
	localparam int CXY_W = 15;
	localparam int COORD_W = 24;
	localparam int FRAC_W = 8;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd2;
	localparam logic [CNT_W-1:0] POINT_COUNT_RESET = 13'd100;

	localparam logic CMD_ELLIPSE = 1'b0;
	localparam logic CMD_RECT = 1'b1;

	// Ellipse angle divider: (idx * 2 * STEPS + n) / (2 * n).
	localparam int EN_W = IDX_W + STEP_W + 2;
	localparam int ED_W = CNT_W + 1;
	localparam int EQ_W = STEP_W + 1;

	localparam int CORDIC_N = 20;
	localparam int ANG_W = 32;
	localparam int Z_W = 33;
	localparam int TRIG_W = 17;
	localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] ATAN_TURN [CORDIC_N] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
		32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304
	};

	// Rectangle side count dividers: Nr * w / (2 * (w + h)).
	localparam int RN_W = CNT_W + SIZE_W;
	localparam int RD_W = SIZE_W + 2;
	localparam int RQ_W = CNT_W - 1;

	// Step along a side: (i * s * 512 + n) / (2 * n).
	localparam int SN_W = 2 * SIZE_W + 10;
	localparam int SD_W = RQ_W + 1;
	localparam int SQ_W = SIZE_W + FRAC_W;

	localparam int E_LAT = EQ_W + CORDIC_N + 3;
	localparam int R_LAT = RQ_W + 2 + SQ_W + 1;
	localparam int PAD = E_LAT - R_LAT;

	typedef struct packed {
		logic cmd;
		logic [SIZE_W-1:0] size_x;
		logic [SIZE_W-1:0] size_y;
		logic [IDX_W-1:0] point_index;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic point_valid;
		logic point_last;
	} rsp_t;

endpackage

// ===== design/sopg_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider that resolves one quotient bit per stage.
module sopg_div #(
	parameter int NW = 26,
	parameter int DW = 14,
	parameter int QW = 13,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_i,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] sb_i,
	output logic          v_o,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] sb_o
);

	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [SW-1:0] sb_s [QW];
	logic          v_s [QW];

	logic [NW-1:0] rem_n [QW];
	logic [QW-1:0] quo_n [QW];
	logic [DW-1:0] den_p [QW];
	logic [SW-1:0] sb_p [QW];
	logic          v_p [QW];

	always_comb begin
		logic [NW-1:0] r;
		logic [QW-1:0] q;
		logic [CW-1:0] dsh;
		for (int j = 0; j < QW; j++) begin
			if (j == 0) begin
				r = num;
				q = '0;
				den_p[j] = den;
				sb_p[j] = sb_i;
				v_p[j] = v_i;
			end else begin
				r = rem_s[j-1];
				q = quo_s[j-1];
				den_p[j] = den_s[j-1];
				sb_p[j] = sb_s[j-1];
				v_p[j] = v_s[j-1];
			end
			dsh = CW'(den_p[j]) << (QW - 1 - j);
			if (CW'(r) >= dsh) begin
				rem_n[j] = NW'(CW'(r) - dsh);
				quo_n[j] = q | (QW'(1) << (QW - 1 - j));
			end else begin
				rem_n[j] = r;
				quo_n[j] = q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < QW; j++) v_s[j] <= 1'b0;
		end else if (en) begin
			for (int j = 0; j < QW; j++) v_s[j] <= v_p[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < QW; j++) begin
				rem_s[j] <= rem_n[j];
				quo_s[j] <= quo_n[j];
				den_s[j] <= den_p[j];
				sb_s[j] <= sb_p[j];
			end
		end
	end

	assign v_o = v_s[QW-1];
	assign quo = quo_s[QW-1];
	assign sb_o = sb_s[QW-1];

endmodule

// ===== design/sopg_cordic.sv =====
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC over one quadrant, one micro-rotation per stage.
module sopg_cordic import sopg_pkg::*; #(
	parameter int SW = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  v_i,
	input  logic signed [Z_W-1:0] z_i,
	input  logic [SW-1:0]         sb_i,
	output logic                  v_o,
	output logic signed [Z_W-1:0] x_o,
	output logic signed [Z_W-1:0] y_o,
	output logic [SW-1:0]         sb_o
);

	logic signed [Z_W-1:0] x_s [CORDIC_N];
	logic signed [Z_W-1:0] y_s [CORDIC_N];
	logic signed [Z_W-1:0] z_s [CORDIC_N];
	logic [SW-1:0]         sb_s [CORDIC_N];
	logic                  v_s [CORDIC_N];

	logic signed [Z_W-1:0] x_n [CORDIC_N];
	logic signed [Z_W-1:0] y_n [CORDIC_N];
	logic signed [Z_W-1:0] z_n [CORDIC_N];
	logic [SW-1:0]         sb_p [CORDIC_N];
	logic                  v_p [CORDIC_N];

	always_comb begin
		logic signed [Z_W-1:0] xp, yp, zp, at;
		for (int j = 0; j < CORDIC_N; j++) begin
			if (j == 0) begin
				xp = $signed(Z_W'(CORDIC_GAIN_Q30));
				yp = '0;
				zp = z_i;
				sb_p[j] = sb_i;
				v_p[j] = v_i;
			end else begin
				xp = x_s[j-1];
				yp = y_s[j-1];
				zp = z_s[j-1];
				sb_p[j] = sb_s[j-1];
				v_p[j] = v_s[j-1];
			end
			at = $signed({1'b0, ATAN_TURN[j]});
			if (zp >= 0) begin
				x_n[j] = xp - (yp >>> j);
				y_n[j] = yp + (xp >>> j);
				z_n[j] = zp - at;
			end else begin
				x_n[j] = xp + (yp >>> j);
				y_n[j] = yp - (xp >>> j);
				z_n[j] = zp + at;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < CORDIC_N; j++) v_s[j] <= 1'b0;
		end else if (en) begin
			for (int j = 0; j < CORDIC_N; j++) v_s[j] <= v_p[j];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < CORDIC_N; j++) begin
				x_s[j] <= x_n[j];
				y_s[j] <= y_n[j];
				z_s[j] <= z_n[j];
				sb_s[j] <= sb_p[j];
			end
		end
	end

	assign v_o = v_s[CORDIC_N-1];
	assign x_o = x_s[CORDIC_N-1];
	assign y_o = y_s[CORDIC_N-1];
	assign sb_o = sb_s[CORDIC_N-1];

endmodule

// ===== design/sopg_delay.sv =====
`timescale 1ns / 1ps
// Stallable delay line with a valid bit that aligns the rectangle path to the ellipse path.
module sopg_delay #(
	parameter int W = 1,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         v_i,
	input  logic [W-1:0] d_i,
	output logic         v_o,
	output logic [W-1:0] d_o
);

	logic [W-1:0] d_s [D];
	logic         v_s [D];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < D; j++) v_s[j] <= 1'b0;
		end else if (en) begin
			for (int j = 0; j < D; j++) begin
				if (j == 0) v_s[j] <= v_i;
				else v_s[j] <= v_s[j-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < D; j++) begin
				if (j == 0) d_s[j] <= d_i;
				else d_s[j] <= d_s[j-1];
			end
		end
	end

	assign v_o = v_s[D-1];
	assign d_o = d_s[D-1];

endmodule

// ===== design/shape_outline_point_generator.sv =====
`timescale 1ns / 1ps
// Top level of the outline point generator for ellipses and rectangles.
//
// A request transfer on req carries a shape code, two sizes and a point index; for each one
// exactly one result transfer leaves on rsp with the point in signed Q8 and valid/last flags.
// The point count and the center are written over the cfg channel, which is always ready;
// they may only change while no request is in flight.
// The block is a 38-stage pipeline that takes a new request every cycle unless rsp is stalled.
// The depth comes from the bit-per-stage dividers (angle, side counts and side step)
// and the 20-stage CORDIC.
// The ellipse and rectangle computations run side by side for every item and the shape code
// picks one at the last stage.
// Reset clears every valid bit and sets the point count to 100 and the center to zero.
// When rsp is stalled the whole pipeline holds and req_ready drops in the same cycle,
// so nothing is lost or repeated; bubbles are not squeezed out.
module shape_outline_point_generator import sopg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef struct packed {
		logic cmd;
		logic ok;
		logic last;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
	} emeta_t;

	typedef struct packed {
		logic [1:0] side;
		logic ok;
		logic last;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
	} rmeta_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [SIZE_W-1:0] w;
		logic [SIZE_W-1:0] h;
	} bmeta_t;

	typedef struct packed {
		logic ok;
		logic last;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
	} pt_t;

	localparam logic [1:0] SIDE_TOP = 2'd0;
	localparam logic [1:0] SIDE_LEFT = 2'd1;
	localparam logic [1:0] SIDE_BOTTOM = 2'd2;
	localparam logic [1:0] SIDE_RIGHT = 2'd3;
	localparam int PW = SIZE_W + TRIG_W + 1;

	function automatic logic signed [TRIG_W-1:0] clamp_q15(input logic signed [Z_W-1:0] v);
		if (v > 32767) return TRIG_W'(32767);
		else if (v < -32767) return TRIG_W'(-32767);
		else return TRIG_W'(v);
	endfunction

	// Configuration registers.
	logic [CNT_W-1:0]        count_q;
	logic signed [CXY_W-1:0] cx_q, cy_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= POINT_COUNT_RESET;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_POINT_COUNT: count_q <= cfg_data[CNT_W-1:0];
				REG_CENTER_X: cx_q <= $signed(cfg_data[CXY_W-1:0]);
				REG_CENTER_Y: cy_q <= $signed(cfg_data[CXY_W-1:0]);
				default: ;
			endcase
		end
	end

	logic [CNT_W-1:0]          n_sat, n_rect;
	logic signed [COORD_W-1:0] cx_fx, cy_fx;

	assign n_sat = (count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_q;
	assign n_rect = {n_sat[CNT_W-1:2], 2'b00};
	assign cx_fx = {{(COORD_W-CXY_W-FRAC_W){cx_q[CXY_W-1]}}, cx_q, {FRAC_W{1'b0}}};
	assign cy_fx = {{(COORD_W-CXY_W-FRAC_W){cy_q[CXY_W-1]}}, cy_q, {FRAC_W{1'b0}}};

	logic en;
	assign en = !rsp_valid || rsp_ready;
	assign req_ready = en;

	// Stage 1: input register with the ellipse angle numerator and the side-count products.
	logic                v_s1;
	logic                cmd_s1;
	logic [SIZE_W-1:0]   w_s1, h_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [EN_W-1:0]     enum_s1;
	logic                eok_s1, elast_s1;
	logic [RN_W-1:0]     pw_s1, ph_s1;
	logic [RD_W-1:0]     rden_s1;
	logic                perz_s1;
	logic [SIZE_W:0]     per;

	assign per = (SIZE_W+1)'(req.size_x) + (SIZE_W+1)'(req.size_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= req_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1 <= req.cmd;
			w_s1 <= req.size_x;
			h_s1 <= req.size_y;
			idx_s1 <= req.point_index;
			enum_s1 <= (EN_W'(req.point_index) << (STEP_W + 1)) + EN_W'(n_sat);
			eok_s1 <= (n_sat != '0) && (CNT_W'(req.point_index) < n_sat);
			elast_s1 <= CNT_W'(req.point_index) == (n_sat - CNT_W'(1));
			pw_s1 <= RN_W'(n_rect) * RN_W'(req.size_x);
			ph_s1 <= RN_W'(n_rect) * RN_W'(req.size_y);
			rden_s1 <= {per, 1'b0};
			perz_s1 <= per == '0;
		end
	end

	// Ellipse path: angle divider, then CORDIC.
	emeta_t          ma_in, ma;
	logic            va;
	logic [EQ_W-1:0] qa;

	assign ma_in = '{cmd: cmd_s1, ok: eok_s1, last: elast_s1, w: w_s1, h: h_s1};

	sopg_div #(.NW(EN_W), .DW(ED_W), .QW(EQ_W), .SW($bits(emeta_t))) u_div_ang (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s1),
		.num(enum_s1), .den({n_sat, 1'b0}), .sb_i(ma_in),
		.v_o(va), .quo(qa), .sb_o(ma)
	);

	logic signed [Z_W-1:0]       z0, xc, yc;
	logic                        vc;
	logic [$bits(emeta_t)+1:0]   sbc;

	assign z0 = $signed(Z_W'(qa[STEP_W-3:0]) << (ANG_W - STEP_W));

	sopg_cordic #(.SW($bits(emeta_t) + 2)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(va),
		.z_i(z0), .sb_i({ma, qa[STEP_W-1:STEP_W-2]}),
		.v_o(vc), .x_o(xc), .y_o(yc), .sb_o(sbc)
	);

	// Stage 35: round to Q1.15, clamp and unfold the quadrant.
	logic signed [Z_W-1:0]    xr, yr;
	logic signed [TRIG_W-1:0] cv, sv, c_n, s_n;

	assign xr = (xc + Z_W'(16384)) >>> 15;
	assign yr = (yc + Z_W'(16384)) >>> 15;
	assign cv = clamp_q15(xr);
	assign sv = clamp_q15(yr);

	always_comb begin
		unique case (sbc[1:0])
			2'd0: begin
				c_n = cv;
				s_n = sv;
			end
			2'd1: begin
				c_n = -sv;
				s_n = cv;
			end
			2'd2: begin
				c_n = -cv;
				s_n = -sv;
			end
			default: begin
				c_n = sv;
				s_n = -cv;
			end
		endcase
	end

	logic                     ev_s35, ev_s36, ev_s37;
	emeta_t                   me_s35, me_s36;
	logic signed [TRIG_W-1:0] c_s35, s_s35;
	logic signed [PW-1:0]     px_s36, py_s36;
	pt_t                      ept_s37;
	logic                     ecmd_s37;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_s35 <= 1'b0;
			ev_s36 <= 1'b0;
			ev_s37 <= 1'b0;
		end else if (en) begin
			ev_s35 <= vc;
			ev_s36 <= ev_s35;
			ev_s37 <= ev_s36;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			me_s35 <= sbc[$bits(emeta_t)+1:2];
			c_s35 <= c_n;
			s_s35 <= s_n;
			me_s36 <= me_s35;
			px_s36 <= $signed(PW'(me_s35.w)) * PW'(c_s35);
			py_s36 <= $signed(PW'(me_s35.h)) * PW'(s_s35);
			ecmd_s37 <= me_s36.cmd;
			ept_s37.ok <= me_s36.ok;
			ept_s37.last <= me_s36.last;
			ept_s37.px <= cx_fx + COORD_W'((px_s36 + PW'(64)) >>> 7);
			ept_s37.py <= cy_fx + COORD_W'((py_s36 + PW'(64)) >>> 7);
		end
	end

	// Rectangle path: side counts.
	bmeta_t          mb_in, mb;
	logic            vb, vn;
	logic [RQ_W-1:0] nw, nh;
	logic            perz;

	assign mb_in = '{idx: idx_s1, w: w_s1, h: h_s1};

	sopg_div #(.NW(RN_W), .DW(RD_W), .QW(RQ_W), .SW($bits(bmeta_t))) u_div_nw (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s1),
		.num(pw_s1), .den(rden_s1), .sb_i(mb_in),
		.v_o(vb), .quo(nw), .sb_o(mb)
	);

	sopg_div #(.NW(RN_W), .DW(RD_W), .QW(RQ_W), .SW(1)) u_div_nh (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(v_s1),
		.num(ph_s1), .den(rden_s1), .sb_i(perz_s1),
		.v_o(vn), .quo(nh), .sb_o(perz)
	);

	// Stage 14: pick the side and the index along it.
	logic [IDX_W+1:0]  e1, e2, e3, tot, ix;
	logic [1:0]        side_n;
	logic [IDX_W+1:0]  i_n;

	assign e1 = (IDX_W+2)'(nw);
	assign e2 = (IDX_W+2)'(nw) + (IDX_W+2)'(nh);
	assign e3 = e2 + (IDX_W+2)'(nw);
	assign tot = e2 + e2;
	assign ix = (IDX_W+2)'(mb.idx);

	always_comb begin
		priority if (ix < e1) begin
			side_n = SIDE_TOP;
			i_n = ix;
		end else if (ix < e2) begin
			side_n = SIDE_LEFT;
			i_n = ix - e1;
		end else if (ix < e3) begin
			side_n = SIDE_BOTTOM;
			i_n = ix - e2;
		end else begin
			side_n = SIDE_RIGHT;
			i_n = ix - e3;
		end
	end

	logic              rv_s14, rv_s15, rv_s36;
	rmeta_t            mr_s14, mr_s15;
	logic [IDX_W-1:0]  i_s14;
	logic [SIZE_W-1:0] s_s14;
	logic [RQ_W-1:0]   nd_s14, nd_s15;
	logic [2*SIZE_W-1:0] prod_s15;
	pt_t               rpt_s36;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s14 <= 1'b0;
			rv_s15 <= 1'b0;
		end else if (en) begin
			rv_s14 <= vb && vn;
			rv_s15 <= rv_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mr_s14.side <= side_n;
			mr_s14.ok <= !perz && (ix < tot);
			mr_s14.last <= ix == (tot - (IDX_W+2)'(1));
			mr_s14.w <= mb.w;
			mr_s14.h <= mb.h;
			i_s14 <= i_n[IDX_W-1:0];
			s_s14 <= side_n[0] ? mb.h : mb.w;
			nd_s14 <= side_n[0] ? nh : nw;
			mr_s15 <= mr_s14;
			nd_s15 <= nd_s14;
			prod_s15 <= (2*SIZE_W)'(i_s14) * (2*SIZE_W)'(s_s14);
		end
	end

	// Step along the side, rounded to nearest in Q8.
	logic            vd;
	logic [SQ_W-1:0] f;
	rmeta_t          md;

	sopg_div #(.NW(SN_W), .DW(SD_W), .QW(SQ_W), .SW($bits(rmeta_t))) u_div_step (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(rv_s15),
		.num((SN_W'(prod_s15) << (FRAC_W + 1)) + SN_W'(nd_s15)),
		.den({nd_s15, 1'b0}), .sb_i(mr_s15),
		.v_o(vd), .quo(f), .sb_o(md)
	);

	// Stage 36: place the point on its side.
	logic signed [COORD_W-1:0] hw, hh, fq, rx_n, ry_n;

	assign hw = COORD_W'({md.w, 7'b0});
	assign hh = COORD_W'({md.h, 7'b0});
	assign fq = COORD_W'(f);

	always_comb begin
		unique case (md.side)
			SIDE_TOP: begin
				rx_n = cx_fx + hw - fq;
				ry_n = cy_fx + hh;
			end
			SIDE_LEFT: begin
				rx_n = cx_fx - hw;
				ry_n = cy_fx + hh - fq;
			end
			SIDE_BOTTOM: begin
				rx_n = cx_fx - hw + fq;
				ry_n = cy_fx - hh;
			end
			SIDE_RIGHT: begin
				rx_n = cx_fx + hw;
				ry_n = cy_fx - hh + fq;
			end
			default: begin
				rx_n = '0;
				ry_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rv_s36 <= 1'b0;
		else if (en) rv_s36 <= vd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rpt_s36.ok <= md.ok;
			rpt_s36.last <= md.last;
			rpt_s36.px <= rx_n;
			rpt_s36.py <= ry_n;
		end
	end

	logic rv_s37;
	pt_t  rpt_s37;

	sopg_delay #(.W($bits(pt_t)), .D(PAD)) u_align (
		.clk(clk), .arst_n(arst_n), .en(en), .v_i(rv_s36),
		.d_i(rpt_s36), .v_o(rv_s37), .d_o(rpt_s37)
	);

	// Stage 38: output register.
	pt_t  sel;
	logic v_s38;
	rsp_t rsp_s38;

	assign sel = (ecmd_s37 == CMD_RECT) ? rpt_s37 : ept_s37;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s38 <= 1'b0;
		else if (en) v_s38 <= ev_s37;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (sel.ok) begin
				rsp_s38.point_x <= sel.px;
				rsp_s38.point_y <= sel.py;
				rsp_s38.point_valid <= 1'b1;
				rsp_s38.point_last <= sel.last;
			end else begin
				rsp_s38 <= '0;
			end
		end
	end

	assign rsp_valid = v_s38;
	assign rsp = rsp_s38;

`ifndef SYNTH
	a_paths_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		ev_s37 == rv_s37)
		else $error("ellipse and rectangle paths out of step");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.point_valid |->
		rsp.point_x == '0 && rsp.point_y == '0 && !rsp.point_last)
		else $error("invalid point carries nonzero fields");

	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.point_last |-> rsp.point_valid)
		else $error("last flag on an invalid point");
`endif

endmodule
